// ===== rtl/ntmf_pkg.sv =====
package ntmf_pkg;

	// Default sizing
	localparam int MAX_TAG_CHARS_DEF = 16;
	localparam int DEPTH_BITS_DEF    = 16;

	// Fixed field widths
	localparam int BYTE_W     = 8;
	localparam int OFFSET_W   = 32;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W  = 2;
	localparam int TAG_LEN_W  = 5;
	localparam int M_DATA_W   = BYTE_W + OFFSET_W;

	// Token characters
	localparam logic [BYTE_W-1:0] CH_LT    = 8'h3C;
	localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
	localparam logic [BYTE_W-1:0] CH_GT    = 8'h3E;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TAG_LOW  = 2'd0,
		CFG_TAG_HIGH = 2'd1,
		CFG_TAG_LEN  = 2'd2
	} cfg_reg_t;

endpackage

// ===== rtl/nested_tag_message_framer_top.sv =====
// A result is registered into the output register when its input byte is taken.
// One byte per cycle in or between messages while output is free and no burst runs.
// An opening at depth zero emits tag length + 1 results; the input stalls while the
// buffered opening drains. Reset (arst_n low, asynchronous) clears window, depth,
// count, burst, output and tag word registers and sets the tag length to 1.
module nested_tag_message_framer_top import ntmf_pkg::*; #(
	parameter int MAX_TAG_CHARS = MAX_TAG_CHARS_DEF,
	parameter int DEPTH_BITS    = DEPTH_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// input stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [BYTE_W-1:0]     s_tdata,   // [7:0] data_byte
	// output stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_DATA_W-1:0]   m_tdata,   // [7:0] message_byte, [39:8] byte_offset
	output logic                  m_tlast,   // last
	// configuration
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int WIN     = MAX_TAG_CHARS + 3;
	localparam int WIN_IW  = $clog2(WIN);
	localparam int FRESH_W = $clog2(WIN + 1);
	localparam int LEN_W   = $clog2(MAX_TAG_CHARS + 1);
	localparam int NBUF    = MAX_TAG_CHARS + 1;

	// Configuration registers
	logic [CFG_DATA_W-1:0] tag_low_q, tag_high_q;
	logic [TAG_LEN_W-1:0]  tag_len_q;

	// Framer state
	logic [BYTE_W-1:0]     win_q [WIN];
	logic [FRESH_W-1:0]    fresh_q;
	logic [DEPTH_BITS-1:0] depth_q;
	logic [OFFSET_W-1:0]   count_q;

	// Opening burst buffer
	logic [BYTE_W-1:0]     buf_q [NBUF];
	logic                  burst_q;
	logic [LEN_W-1:0]      burst_idx_q, burst_len_q;

	// Output register
	logic                  out_valid_q;
	logic [BYTE_W-1:0]     out_byte_q;
	logic [OFFSET_W-1:0]   out_offset_q;
	logic                  out_last_q;

	logic                  out_free, s_acc;
	logic [BYTE_W-1:0]     win_next [WIN];
	logic [BYTE_W-1:0]     buf_next [NBUF];
	logic [FRESH_W-1:0]    fresh_inc;
	logic [LEN_W-1:0]      eff_len;
	logic [WIN_IW-1:0]     len_w;
	logic [2*CFG_DATA_W-1:0] tag_all;
	logic                  opened, closed;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = !burst_q && out_free;
	assign s_acc    = s_tvalid && s_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_offset_q, out_byte_q};
	assign m_tlast  = out_last_q;

	// Effective tag length, clamped to 1..MAX_TAG_CHARS
	always_comb begin
		if (tag_len_q == '0) begin
			eff_len = LEN_W'(1);
		end else if (tag_len_q > TAG_LEN_W'(MAX_TAG_CHARS)) begin
			eff_len = LEN_W'(MAX_TAG_CHARS);
		end else begin
			eff_len = LEN_W'(tag_len_q);
		end
	end

	assign len_w   = WIN_IW'(eff_len);
	assign tag_all = {tag_high_q, tag_low_q};
	assign fresh_inc = (fresh_q == FRESH_W'(WIN)) ? fresh_q : fresh_q + FRESH_W'(1);

	// Window after shifting in the new byte
	always_comb begin
		win_next[0] = s_tdata;
		for (int k = 1; k < WIN; k++) begin
			win_next[k] = win_q[k-1];
		end
	end

	// Opening and closing token compares, one compare per tag character
	always_comb begin
		opened = (fresh_inc >= FRESH_W'(eff_len) + FRESH_W'(1)) && (win_next[len_w] == CH_LT);
		closed = (fresh_inc >= FRESH_W'(eff_len) + FRESH_W'(3))
			&& (win_next[len_w + WIN_IW'(2)] == CH_LT)
			&& (win_next[len_w + WIN_IW'(1)] == CH_SLASH)
			&& (win_next[0] == CH_GT);
		for (int i = 0; i < MAX_TAG_CHARS; i++) begin
			if (LEN_W'(i) < eff_len) begin
				if (win_next[len_w - WIN_IW'(i) - WIN_IW'(1)] != tag_all[8*i +: 8]) begin
					opened = 1'b0;
				end
				if (win_next[len_w - WIN_IW'(i)] != tag_all[8*i +: 8]) begin
					closed = 1'b0;
				end
			end
		end
	end

	// Opening bytes in emit order
	always_comb begin
		for (int i = 0; i < NBUF; i++) begin
			if (LEN_W'(i) <= eff_len) begin
				buf_next[i] = win_next[len_w - WIN_IW'(i)];
			end else begin
				buf_next[i] = '0;
			end
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_low_q  <= '0;
			tag_high_q <= '0;
			tag_len_q  <= TAG_LEN_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_TAG_LOW:  tag_low_q  <= cfg_wdata;
				CFG_TAG_HIGH: tag_high_q <= cfg_wdata;
				CFG_TAG_LEN:  tag_len_q  <= cfg_wdata[TAG_LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Burst buffer payload
	always_ff @(posedge clk) begin
		if (s_acc && depth_q == '0 && opened) begin
			for (int i = 0; i < NBUF; i++) begin
				buf_q[i] <= buf_next[i];
			end
		end
	end

	// Framer state, burst control and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < WIN; k++) begin
				win_q[k] <= '0;
			end
			fresh_q      <= '0;
			depth_q      <= '0;
			count_q      <= '0;
			burst_q      <= 1'b0;
			burst_idx_q  <= '0;
			burst_len_q  <= '0;
			out_valid_q  <= 1'b0;
			out_byte_q   <= '0;
			out_offset_q <= '0;
			out_last_q   <= 1'b0;
		end else begin
			if (out_free) begin
				out_valid_q <= 1'b0;
			end

			// drain buffered opening bytes
			if (burst_q && out_free) begin
				out_valid_q  <= 1'b1;
				out_byte_q   <= buf_q[burst_idx_q];
				out_offset_q <= OFFSET_W'(burst_idx_q);
				out_last_q   <= 1'b0;
				if (burst_idx_q == burst_len_q) begin
					burst_q <= 1'b0;
				end
				burst_idx_q <= burst_idx_q + LEN_W'(1);
			end

			// accepted byte
			if (s_acc) begin
				for (int k = 0; k < WIN; k++) begin
					win_q[k] <= win_next[k];
				end
				fresh_q <= fresh_inc;
				if (depth_q == '0) begin
					if (opened) begin
						depth_q      <= DEPTH_BITS'(1);
						count_q      <= OFFSET_W'(eff_len) + OFFSET_W'(1);
						fresh_q      <= '0;
						out_valid_q  <= 1'b1;
						out_byte_q   <= buf_next[0];
						out_offset_q <= '0;
						out_last_q   <= 1'b0;
						burst_q      <= 1'b1;
						burst_idx_q  <= LEN_W'(1);
						burst_len_q  <= eff_len;
					end
				end else begin
					if (closed) begin
						depth_q <= depth_q - DEPTH_BITS'(1);
						fresh_q <= '0;
					end else if (opened) begin
						if (depth_q != '1) begin
							depth_q <= depth_q + DEPTH_BITS'(1);
						end
						fresh_q <= '0;
					end
					out_valid_q  <= 1'b1;
					out_byte_q   <= s_tdata;
					out_offset_q <= count_q;
					out_last_q   <= closed && (depth_q == DEPTH_BITS'(1));
					if (closed && depth_q == DEPTH_BITS'(1)) begin
						count_q <= '0;
					end else if (count_q != '1) begin
						count_q <= count_q + OFFSET_W'(1);
					end
				end
			end
		end
	end

	// Between messages the offset count is idle at zero
	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		(depth_q == '0) |-> (count_q == '0))
		else $error("offset count nonzero at depth zero");

	// A pending last result means the message has fully closed
	a_last_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_last_q) |-> (depth_q == '0))
		else $error("last result pending while depth nonzero");

	// An opening burst only runs at depth one
	a_burst_depth: assert property (@(posedge clk) disable iff (!arst_n)
		burst_q |-> (depth_q == DEPTH_BITS'(1)))
		else $error("opening burst outside depth one");

	// Burst index stays within the buffered opening
	a_burst_idx: assert property (@(posedge clk) disable iff (!arst_n)
		burst_q |-> (burst_idx_q != '0 && burst_idx_q <= burst_len_q))
		else $error("burst index out of range");

endmodule

// ===== sim/tb_nested_tag_message_framer_top.sv =====
`timescale 1ns / 1ps

module tb_nested_tag_message_framer_top import ntmf_pkg::*;;

	localparam int WIN_LEN     = MAX_TAG_CHARS_DEF + 3;
	localparam int QUIET_LIMIT = 1000;
	localparam int DRAIN_WAIT  = 8;
	localparam int SHOW_LIMIT  = 100;
	localparam int NEST_LEVELS = 6;

	// one framed output byte as the block should emit it
	typedef struct packed {
		logic [BYTE_W-1:0]   data;
		logic [OFFSET_W-1:0] offset;
		logic                last;
	} framed_byte_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [BYTE_W-1:0]     s_tdata = '0;   // [7:0] data_byte
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_DATA_W-1:0]   m_tdata;        // [7:0] message_byte, [39:8] byte_offset
	logic                  m_tlast;        // last
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	// pending stream bytes and framed bytes still owed by the block
	logic [BYTE_W-1:0] stream_bytes[$];
	framed_byte_t      expected_bytes[$];

	// framer state as predicted
	logic [BYTE_W-1:0]         byte_hist [WIN_LEN];
	logic [DEPTH_BITS_DEF-1:0] nest_depth;
	logic [OFFSET_W-1:0]       msg_pos;
	int                        fresh_cnt;
	logic [CFG_DATA_W-1:0]     tag_lo;
	logic [CFG_DATA_W-1:0]     tag_hi;
	logic [TAG_LEN_W-1:0]      tag_len;

	int fail_count = 0;
	int src_hold = 0;
	int sink_hold = 0;
	int quiet_cycles = 0;
	bit bursty = 1'b1;

	nested_tag_message_framer_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #4 clk = ~clk;

	// effective tag length, clamped to 1..MAX_TAG_CHARS
	function automatic int tag_span();
		int n;
		n = int'(tag_len);
		if (n == 0) n = 1;
		if (n > MAX_TAG_CHARS_DEF) n = MAX_TAG_CHARS_DEF;
		return n;
	endfunction

	function automatic logic [BYTE_W-1:0] tag_byte(input int i);
		if (i < 8) begin
			return tag_lo[8*i +: 8];
		end else begin
			return tag_hi[8*(i-8) +: 8];
		end
	endfunction

	// history ends with '<' tag
	function automatic bit opening_seen(input int n);
		int i;
		if (fresh_cnt < n + 1) return 1'b0;
		if (byte_hist[n] != CH_LT) return 1'b0;
		for (i = 0; i < n; i++)
			if (byte_hist[n-1-i] != tag_byte(i)) return 1'b0;
		return 1'b1;
	endfunction

	// history ends with '</' tag '>'
	function automatic bit closing_seen(input int n);
		int i;
		if (fresh_cnt < n + 3) return 1'b0;
		if (byte_hist[n+2] != CH_LT || byte_hist[n+1] != CH_SLASH) return 1'b0;
		if (byte_hist[0] != CH_GT) return 1'b0;
		for (i = 0; i < n; i++)
			if (byte_hist[n-i] != tag_byte(i)) return 1'b0;
		return 1'b1;
	endfunction

	// advance the framer by one stream byte and queue the bytes it emits
	task automatic predict_framed_bytes(input logic [BYTE_W-1:0] b);
		int n;
		int i;
		bit opened;
		bit closed;
		framed_byte_t r;
		n = tag_span();
		for (i = WIN_LEN - 1; i > 0; i--) byte_hist[i] = byte_hist[i-1];
		byte_hist[0] = b;
		if (fresh_cnt < WIN_LEN) fresh_cnt++;
		closed = closing_seen(n);
		opened = opening_seen(n);

		// between messages: drop until an opening completes, then flush it
		if (nest_depth == 0) begin
			if (opened) begin
				for (i = 0; i <= n; i++) begin
					r.data = byte_hist[n-i];
					r.offset = OFFSET_W'(i);
					r.last = 1'b0;
					expected_bytes.push_back(r);
				end
				nest_depth = DEPTH_BITS_DEF'(1);
				msg_pos = OFFSET_W'(n + 1);
				fresh_cnt = 0;
			end
			return;
		end

		// inside a message: closing wins over opening, depth saturates
		if (closed) begin
			nest_depth--;
			fresh_cnt = 0;
		end else if (opened) begin
			if (nest_depth != '1) nest_depth++;
			fresh_cnt = 0;
		end
		r.data = b;
		r.offset = msg_pos;
		r.last = closed && nest_depth == 0;
		expected_bytes.push_back(r);
		if (r.last) msg_pos = '0;
		else if (msg_pos != '1) msg_pos++;
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (fail_count < SHOW_LIMIT)
			$display("[%0t] MISMATCH %s: got %0h want %0h", $time, what, got, want);
		fail_count++;
	endtask

	// input driver
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) predict_framed_bytes(s_tdata);
			if (!s_tvalid || s_tready) begin
				if (src_hold > 0) begin
					src_hold--;
					s_tvalid <= 1'b0;
				end else if (stream_bytes.size() > 0) begin
					s_tvalid <= 1'b1;
					s_tdata <= stream_bytes.pop_front();
					if (bursty && $urandom_range(0, 9) == 0) src_hold = $urandom_range(1, 9);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// output monitor and backpressure
	always @(posedge clk) begin
		framed_byte_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_bytes.size() == 0) begin
					report_mismatch("unexpected output byte", 64'(m_tdata), '0);
				end else begin
					want = expected_bytes.pop_front();
					if (m_tdata[BYTE_W-1:0] !== want.data)
						report_mismatch("message_byte", 64'(m_tdata[BYTE_W-1:0]),
							64'(want.data));
					if (m_tdata[BYTE_W +: OFFSET_W] !== want.offset)
						report_mismatch("byte_offset", 64'(m_tdata[BYTE_W +: OFFSET_W]),
							64'(want.offset));
					if (m_tlast !== want.last)
						report_mismatch("last", 64'(m_tlast), 64'(want.last));
				end
			end
			if (sink_hold > 0) begin
				sink_hold--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (bursty && $urandom_range(0, 5) == 0) sink_hold = $urandom_range(1, 9);
			end
		end
	end

	// watchdog: too long without any request moving
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) quiet_cycles = 0;
			else quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_TAG_LOW:  tag_lo = val;
			CFG_TAG_HIGH: tag_hi = val;
			CFG_TAG_LEN:  tag_len = val[TAG_LEN_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_tag(input logic [CFG_DATA_W-1:0] lo, input logic [CFG_DATA_W-1:0] hi,
			input int n);
		write_reg(CFG_TAG_LOW, lo);
		write_reg(CFG_TAG_HIGH, hi);
		write_reg(CFG_TAG_LEN, CFG_DATA_W'(n));
	endtask

	// wait for every request to go through and the block to settle
	task automatic wait_drained();
		do @(negedge clk);
		while (stream_bytes.size() != 0 || s_tvalid || expected_bytes.size() != 0);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	// tag words without '<'
	function automatic logic [CFG_DATA_W-1:0] plain_tag_word();
		logic [CFG_DATA_W-1:0] w;
		logic [BYTE_W-1:0] b;
		int i;
		for (i = 0; i < 8; i++) begin
			b = BYTE_W'($urandom_range(0, 255));
			if (b == CH_LT) b = b ^ 8'h01;
			w[8*i +: 8] = b;
		end
		return w;
	endfunction

	// tag words built mostly from token characters
	function automatic logic [CFG_DATA_W-1:0] tricky_tag_word();
		logic [CFG_DATA_W-1:0] w;
		int i;
		for (i = 0; i < 8; i++) begin
			case ($urandom_range(0, 3))
				0: w[8*i +: 8] = CH_LT;
				1: w[8*i +: 8] = CH_SLASH;
				2: w[8*i +: 8] = CH_GT;
				default: w[8*i +: 8] = BYTE_W'($urandom_range(0, 255));
			endcase
		end
		return w;
	endfunction

	task automatic push_random(input int n);
		repeat (n) stream_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
	endtask

	task automatic push_tag_open();
		int i;
		stream_bytes.push_back(CH_LT);
		for (i = 0; i < tag_span(); i++) stream_bytes.push_back(tag_byte(i));
	endtask

	task automatic push_tag_close();
		int i;
		stream_bytes.push_back(CH_LT);
		stream_bytes.push_back(CH_SLASH);
		for (i = 0; i < tag_span(); i++) stream_bytes.push_back(tag_byte(i));
		stream_bytes.push_back(CH_GT);
	endtask

	// closing with one tag character off
	task automatic push_bad_close();
		int i;
		int k;
		k = $urandom_range(0, tag_span() - 1);
		stream_bytes.push_back(CH_LT);
		stream_bytes.push_back(CH_SLASH);
		for (i = 0; i < tag_span(); i++)
			stream_bytes.push_back(i == k ? tag_byte(i) ^ 8'h01 : tag_byte(i));
		stream_bytes.push_back(CH_GT);
	endtask

	// well-formed message with random content and nesting
	task automatic push_frame(input int lvl);
		push_tag_open();
		repeat ($urandom_range(0, 4)) begin
			case ($urandom_range(0, 5))
				3: if (lvl < 3) push_frame(lvl + 1); else push_random(1);
				4: push_bad_close();
				5: begin
					stream_bytes.push_back(CH_LT);
					push_random($urandom_range(0, 2));
				end
				default: push_random($urandom_range(1, 6));
			endcase
		end
		push_tag_close();
	endtask

	// junk between messages
	task automatic push_noise();
		int i;
		case ($urandom_range(0, 3))
			0: push_random($urandom_range(1, 5));
			1: begin
				// opening cut short
				stream_bytes.push_back(CH_LT);
				if (tag_span() > 1) begin
					for (i = 0; i < $urandom_range(1, tag_span() - 1); i++)
						stream_bytes.push_back(tag_byte(i));
				end else begin
					stream_bytes.push_back(tag_byte(0) ^ 8'h20);
				end
			end
			2: push_tag_close();
			default: push_bad_close();
		endcase
	endtask

	task automatic push_traffic(input int n);
		int target;
		target = stream_bytes.size() + n;
		while (stream_bytes.size() < target) begin
			if ($urandom_range(0, 9) < 7) push_frame(0);
			else push_noise();
		end
	endtask

	initial begin
		byte_hist = '{default: '0};
		nest_depth = '0;
		msg_pos = '0;
		fresh_cnt = 0;
		tag_lo = '0;
		tag_hi = '0;
		tag_len = TAG_LEN_W'(1);

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset tag: single NUL character
		// closing at depth zero is dropped
		push_tag_close();
		// opening, extreme content bytes, nested opening, two closings
		push_tag_open();
		stream_bytes.push_back(8'hFF);
		stream_bytes.push_back(8'h00);
		push_tag_open();
		stream_bytes.push_back(8'h80);
		push_tag_close();
		push_tag_close();
		wait_drained();

		// longest tag
		set_tag(plain_tag_word(), plain_tag_word(), MAX_TAG_CHARS_DEF);
		push_traffic(20);
		wait_drained();

		// zero length reads as one; leave a message open across the change
		set_tag(plain_tag_word(), '0, 0);
		push_traffic(25);
		push_tag_open();
		push_random(3);
		wait_drained();

		// oversize length clamps, all-ones tag, close the carried message
		bursty = 1'b0;
		set_tag('1, '1, 31);
		push_random(4);
		push_tag_close();
		push_traffic(20);
		wait_drained();

		// middle lengths
		bursty = 1'b1;
		set_tag(plain_tag_word(), plain_tag_word(), $urandom_range(2, 15));
		push_traffic(30);
		wait_drained();

		// tag of a lone '<', then tags made of token characters
		set_tag({plain_tag_word()} << 8 | CFG_DATA_W'(CH_LT), '0, 1);
		push_traffic(15);
		wait_drained();
		set_tag(tricky_tag_word(), tricky_tag_word(), $urandom_range(1, 4));
		push_traffic(20);
		wait_drained();

		// other oversize lengths
		set_tag(plain_tag_word(), plain_tag_word(), $urandom_range(17, 30));
		push_traffic(20);
		wait_drained();

		// deep nesting, no idling from here on
		bursty = 1'b0;
		set_tag({plain_tag_word()} << 8 | 64'h71, '0, 1);
		repeat (NEST_LEVELS) push_tag_open();
		repeat (NEST_LEVELS) push_tag_close();
		push_frame(0);
		wait_drained();

		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ===== nested_tag_message_framer_top.f =====
rtl/ntmf_pkg.sv
rtl/nested_tag_message_framer_top.sv
sim/tb_nested_tag_message_framer_top.sv
